[rtl/scratch_page_slot_allocator_unit_macros.svh]
// Assertion helpers for the allocator unit RTL; empty when SYNTH is defined.
`ifndef SCRATCH_PAGE_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define SCRATCH_PAGE_SLOT_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define SPSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spsa: implication check failed");
// next-cycle implication, checked out of reset
`define SPSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spsa: next-cycle check failed");
// condition that must never hold
`define SPSA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("spsa: forbidden condition seen");
`else
`define SPSA_ASSERT_IMPL(lbl, ante, cons)
`define SPSA_ASSERT_NEXT(lbl, ante, cons)
`define SPSA_ASSERT_NEVER(lbl, cond)
`endif

`endif

[rtl/spsa_pkg.sv]
`timescale 1ns / 1ps
package spsa_pkg;

  localparam int PAGE_W         = 52;
  localparam int FRAME_W        = 40;
  localparam int FRAME_SHIFT    = 12;
  localparam int IDX_W          = 9;
  localparam int PTE_W          = 64;
  localparam int BM_WORD_W      = 64;
  localparam int BM_BIT_W       = 6;
  localparam int BM_BYTES       = 8;
  localparam int BM_BYTE_W      = 3;
  localparam int BM_ADDR_MAX_W  = 6;
  localparam int SLOT_IDX_MAX_W = 12;

  localparam logic [FRAME_SHIFT-1:0] ENTRY_FLAGS = 12'h003;

  localparam logic [1:0] ACT_ALLOC    = 2'd0;
  localparam logic [1:0] ACT_REASSIGN = 2'd1;
  localparam logic [1:0] ACT_FREE     = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [PAGE_W-1:0]  virt_page;
    logic [FRAME_W-1:0] phys_frame;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [PAGE_W-1:0]  slot_page;
    logic               entry_written;
    logic [IDX_W-1:0]   entry_index;
    logic [PAGE_W-1:0]  entry_value;
    logic               flush_page;
  } out_item_t;

  typedef struct packed {
    logic                     rd_en;
    logic [BM_ADDR_MAX_W-1:0] rd_addr;
    logic                     wr_en;
    logic [BM_ADDR_MAX_W-1:0] wr_addr;
    logic [BM_WORD_W-1:0]     wr_data;
  } bm_req_t;

  typedef struct packed {
    logic                      wr_en;
    logic [SLOT_IDX_MAX_W-1:0] wr_addr;
    logic [PTE_W-1:0]          wr_data;
  } pte_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_PICK
  } st_t;

endpackage

[rtl/scratch_page_slot_allocator_unit.sv]
`timescale 1ns / 1ps
// Reassign, out-of-window and unused commands end in DECODE; free reads the bitmap
// word in DECODE and clears the bit in CHECK; allocate scans words from word 0, one
// word per CHECK pass, then marks the slot in PICK, or ends in CHECK when full. One
// command in flight: start is taken only in IDLE, which the FSM reenters as the
// result strobe rises. The result strobe lasts one cycle and cannot be stalled.
// Reset (rst_n low, synchronous): bitmap reads all clear, window base 0, FSM idle.
`include "scratch_page_slot_allocator_unit_macros.svh"
module scratch_page_slot_allocator_unit import spsa_pkg::*; #(
  parameter int TABLE_COUNT       = 1,
  parameter int ENTRIES_PER_TABLE = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PAGE_W-1:0] cfg_data
);

  localparam int SLOT_COUNT = TABLE_COUNT * ENTRIES_PER_TABLE;
  localparam int WORDS      = SLOT_COUNT / BM_WORD_W;
  localparam int WB         = $clog2(WORDS);
  localparam int SIW        = WB + BM_BIT_W;

  st_t                  state_r, state_nxt;
  logic [1:0]           act_r, act_nxt;
  logic [PAGE_W-1:0]    vpage_r, vpage_nxt;
  logic [FRAME_W-1:0]   frm_r, frm_nxt;
  logic [PAGE_W-1:0]    off_r, off_nxt;
  logic [PAGE_W-1:0]    base_r;
  logic [WB-1:0]        scan_r, scan_nxt;
  logic [BM_BYTE_W-1:0] bsel_r, bsel_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic [BM_WORD_W-1:0] word_r, word_nxt;
  out_item_t            out_r, out_nxt;
  logic                 out_valid_r, out_load;

  bm_req_t              bm_req;
  pte_req_t             pte_req;
  logic [BM_WORD_W-1:0] rd_word;

  logic                 in_win;
  logic                 scan_last;
  logic                 has_zero;
  logic [BM_BYTE_W-1:0] zbyte;
  logic [BM_BYTE_W-1:0] zbit;
  logic [BM_BIT_W-1:0]  pick_bit;
  logic [SIW-1:0]       pick_idx;
  logic [SIW-1:0]       off_idx;
  logic [PAGE_W-1:0]    entry;

  spsa_bitmap_mem #(.WORDS(WORDS)) u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (bm_req),
    .rd_word (rd_word)
  );

  spsa_pte_mem #(.ENTRIES(SLOT_COUNT)) u_pte (
    .clk (clk),
    .req (pte_req)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // decode helpers
  assign in_win    = (off_r < PAGE_W'(SLOT_COUNT));
  assign scan_last = (scan_r == WB'(WORDS - 1));
  assign off_idx   = off_r[SIW-1:0];
  assign entry     = {frm_r, ENTRY_FLAGS};
  assign pick_bit  = {bsel_r, zbit};
  assign pick_idx  = {scan_r, pick_bit};

  // find the first byte of the read word that has a clear bit
  always_comb begin
    zbyte    = '0;
    has_zero = 1'b0;
    for (int i = BM_BYTES - 1; i >= 0; i--) begin
      if (rd_word[i*8 +: 8] != 8'hFF) begin
        zbyte    = BM_BYTE_W'(i);
        has_zero = 1'b1;
      end
    end
  end

  // find the first clear bit inside the chosen byte
  always_comb begin
    zbit = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!byte_r[j]) begin
        zbit = BM_BYTE_W'(j);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (act_r == ACT_ALLOC || (act_r == ACT_FREE && in_win)) state_nxt = ST_CHECK;
        else state_nxt = ST_IDLE;
      end
      ST_CHECK: begin
        if (act_r == ACT_ALLOC) begin
          if (has_zero) state_nxt = ST_PICK;
          else if (scan_last) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PICK: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory requests, datapath updates and result
  always_comb begin
    act_nxt   = act_r;
    vpage_nxt = vpage_r;
    frm_nxt   = frm_r;
    off_nxt   = off_r;
    scan_nxt  = scan_r;
    bsel_nxt  = bsel_r;
    byte_nxt  = byte_r;
    word_nxt  = word_r;
    bm_req    = '0;
    pte_req   = '0;
    out_nxt   = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // latch the command beat
        if (start) begin
          act_nxt   = in_data.action;
          vpage_nxt = in_data.virt_page;
          frm_nxt   = in_data.phys_frame;
          off_nxt   = in_data.virt_page - base_r;
        end
      end
      ST_DECODE: begin
        if (act_r == ACT_ALLOC) begin
          scan_nxt       = '0;
          bm_req.rd_en   = 1'b1;
          bm_req.rd_addr = '0;
        end else if (act_r == ACT_REASSIGN || act_r == ACT_FREE) begin
          if (!in_win) begin
            out_nxt.slot_page = vpage_r;
            out_load          = 1'b1;
          end else if (act_r == ACT_REASSIGN) begin
            pte_req.wr_en         = 1'b1;
            pte_req.wr_addr       = SLOT_IDX_MAX_W'(off_idx);
            pte_req.wr_data       = PTE_W'(entry);
            out_nxt.ok            = 1'b1;
            out_nxt.slot_page     = vpage_r;
            out_nxt.entry_written = 1'b1;
            out_nxt.entry_index   = off_idx[IDX_W-1:0];
            out_nxt.entry_value   = entry;
            out_nxt.flush_page    = 1'b1;
            out_load              = 1'b1;
          end else begin
            bm_req.rd_en   = 1'b1;
            bm_req.rd_addr = BM_ADDR_MAX_W'(off_idx[SIW-1:BM_BIT_W]);
          end
        end else begin
          // unused action code: all-zero result
          out_load = 1'b1;
        end
      end
      ST_CHECK: begin
        if (act_r == ACT_ALLOC) begin
          if (has_zero) begin
            bsel_nxt = zbyte;
            byte_nxt = rd_word[zbyte*8 +: 8];
            word_nxt = rd_word;
          end else if (scan_last) begin
            out_load = 1'b1;
          end else begin
            scan_nxt       = scan_r + 1'b1;
            bm_req.rd_en   = 1'b1;
            bm_req.rd_addr = BM_ADDR_MAX_W'(scan_r + 1'b1);
          end
        end else begin
          // free: clear the addressed bit and write the word back
          bm_req.wr_en      = 1'b1;
          bm_req.wr_addr    = BM_ADDR_MAX_W'(off_idx[SIW-1:BM_BIT_W]);
          bm_req.wr_data    = rd_word & ~(BM_WORD_W'(1) << off_idx[BM_BIT_W-1:0]);
          out_nxt.ok        = 1'b1;
          out_nxt.slot_page = vpage_r;
          out_load          = 1'b1;
        end
      end
      ST_PICK: begin
        // mark the slot used, write its entry and report it
        bm_req.wr_en          = 1'b1;
        bm_req.wr_addr        = BM_ADDR_MAX_W'(scan_r);
        bm_req.wr_data        = word_r | (BM_WORD_W'(1) << pick_bit);
        pte_req.wr_en         = 1'b1;
        pte_req.wr_addr       = SLOT_IDX_MAX_W'(pick_idx);
        pte_req.wr_data       = PTE_W'(entry);
        out_nxt.ok            = 1'b1;
        out_nxt.slot_page     = base_r + PAGE_W'(pick_idx);
        out_nxt.entry_written = 1'b1;
        out_nxt.entry_index   = pick_idx[IDX_W-1:0];
        out_nxt.entry_value   = entry;
        out_nxt.flush_page    = 1'b1;
        out_load              = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    vpage_r <= vpage_nxt;
    frm_r   <= frm_nxt;
    off_r   <= off_nxt;
    scan_r  <= scan_nxt;
    bsel_r  <= bsel_nxt;
    byte_r  <= byte_nxt;
    word_r  <= word_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  `SPSA_ASSERT_IMPL(a_strobe_after_work, out_valid, $past(busy))
  `SPSA_ASSERT_NEVER(a_bm_no_rd_wr_overlap, bm_req.rd_en && bm_req.wr_en)
  `SPSA_ASSERT_NEXT(a_start_enters_decode, start && !busy, state_r == ST_DECODE)
  `SPSA_ASSERT_IMPL(a_written_entry_flushed, out_valid && out_data.entry_written,
                    out_data.ok && out_data.flush_page)

endmodule

[rtl/spsa_bitmap_mem.sv]
`timescale 1ns / 1ps
module spsa_bitmap_mem import spsa_pkg::*; #(
  parameter int WORDS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bm_req_t              req,
  output logic [BM_WORD_W-1:0] rd_word
);

  localparam int AW = $clog2(WORDS);

  logic [BM_WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]     vld_r;
  logic [BM_WORD_W-1:0] rdata_r;
  logic                 rvld_r;

  // storage array: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  // track written words so that reset reads as all clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= vld_r[req.rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_word = rvld_r ? rdata_r : '0;

endmodule

[rtl/spsa_pte_mem.sv]
`timescale 1ns / 1ps
module spsa_pte_mem import spsa_pkg::*; #(
  parameter int ENTRIES = 512
) (
  input  logic     clk,
  input  pte_req_t req
);

  localparam int AW = $clog2(ENTRIES);

  logic [PTE_W-1:0] mem [ENTRIES];

  // write the page table entry
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

endmodule
